// File: sv/letter_bigram_histogram_top_assert.svh
// assertion macros for the letter bigram histogram
`ifndef LETTER_BIGRAM_HISTOGRAM_TOP_ASSERT_SVH
`define LETTER_BIGRAM_HISTOGRAM_TOP_ASSERT_SVH

`ifndef SYNTH

// condition must never hold at a clock edge outside reset
`define LBH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define LBH_ASSERT_NEVER(lbl, cond, msg)
`define LBH_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

// File: sv/lbh_pkg.sv
// shared constants, types and helper functions for the letter bigram histogram
package lbh_pkg;

  localparam int COUNT_WIDTH   = 32;
  localparam int ALPHABET_SIZE = 26;
  localparam int PAIR_DEPTH    = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int LETTER_AW     = $clog2(ALPHABET_SIZE);
  localparam int PAIR_AW       = $clog2(PAIR_DEPTH);

  localparam int REQ_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_W      = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_FEED        = 2'd0,
    REQ_READ_LETTER = 2'd1,
    REQ_READ_PAIR   = 2'd2
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] data;
  } push_t;

  // saturating increment
  function automatic count_t bump(count_t c);
    return (&c) ? c : count_t'(c + count_t'(1));
  endfunction

  // clip a count to the output field
  function automatic logic [OUT_W-1:0] clip_out(count_t c);
    logic [COUNT_WIDTH+OUT_W-1:0] wide;
    wide = (COUNT_WIDTH + OUT_W)'(c);
    return (|wide[COUNT_WIDTH+OUT_W-1:OUT_W]) ? '1 : wide[OUT_W-1:0];
  endfunction

  // row-major pair table address
  function automatic logic [PAIR_AW-1:0] pair_index(logic [IDX_W-1:0] a,
                                                    logic [IDX_W-1:0] b);
    return PAIR_AW'(PAIR_AW'(a) * PAIR_AW'(ALPHABET_SIZE) + PAIR_AW'(b));
  endfunction

endpackage

// File: sv/lbh_out_fifo.sv
// small result queue that decouples the counter pipeline from the output stream
module lbh_out_fifo import lbh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  output logic [FIFO_CW-1:0] level,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata    // count_value[31:0]
);

  logic [OUT_W-1:0]   slot [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  assign m_tvalid = (level != '0);
  assign m_tdata  = slot[rd_ptr];
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot[wr_ptr] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= FIFO_AW'(wr_ptr + FIFO_AW'(1));
      end
      if (pop) begin
        rd_ptr <= FIFO_AW'(rd_ptr + FIFO_AW'(1));
      end
      level <= FIFO_CW'(level + FIFO_CW'(push.valid) - FIFO_CW'(pop));
    end
  end

endmodule

// File: sv/letter_bigram_histogram_top.sv
// letter and letter-pair histogram: counter memories, update pipeline and readout
//
// usage
//   input stream (s_*): one transaction per request. s_tuser carries the request
//   kind (feed a text byte, read a letter count, read a pair count); s_tdata
//   carries the byte and the letter indices. feeds give no output transaction,
//   reads give exactly one count on the output stream (m_*), in request order.
//   letters are case-folded; a pair is counted when two letters arrive back to
//   back in the feed, and any non-letter byte breaks the chain.
// pipeline
//   one request per cycle while s_tready is high. a read result passes the update
//   stage register and the result queue before m_tvalid offers it. the counter
//   read-modify-write uses a synchronous memory read; a write forwarding register
//   per memory covers updates to the same counter on consecutive cycles.
// reset
//   rst clears the pipeline, the pair chain and the result queue, then a
//   clearing sweep zeroes both counter memories while s_tready stays low.
// stall
//   results wait in a four-entry queue; outside the clearing sweep, s_tready
//   drops only when the queue together with a read in flight would be full.

`include "letter_bigram_histogram_top_assert.svh"

module letter_bigram_histogram_top import lbh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // char_code[7:0], first_index[12:8],
                                          // second_index[17:13], zero pad[23:18]
  input  logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata    // count_value[31:0]
);

  // what the update stage needs to know about one accepted transaction
  typedef struct packed {
    logic                 do_letter;   // bump the letter counter
    logic                 do_pair;     // bump the pair counter
    logic                 is_read;     // produce an output transaction
    logic                 sel_pair;    // read returns the pair count
    logic                 zero;        // read index out of range
    logic [LETTER_AW-1:0] letter_addr;
    logic [PAIR_AW-1:0]   pair_addr;
  } stage_t;

  // input field split
  logic [CHAR_W-1:0] in_char;
  logic [IDX_W-1:0]  in_first;
  logic [IDX_W-1:0]  in_second;
  logic [CHAR_W-1:0] folded;
  logic              in_is_letter;
  logic [IDX_W-1:0]  in_num;
  logic              in_accept;

  // pair chain
  logic             prev_is_letter;
  logic             prev_is_letter_next;
  logic [IDX_W-1:0] prev_letter;
  logic [IDX_W-1:0] prev_letter_next;

  // update stage
  stage_t s1;
  stage_t s1_next;
  logic   s1_valid;

  // counter memories
  count_t letter_mem [ALPHABET_SIZE];
  count_t pair_mem   [PAIR_DEPTH];
  count_t letter_rd;
  count_t pair_rd;

  logic                 letter_we;
  logic [LETTER_AW-1:0] letter_waddr;
  count_t               letter_wdata;
  logic                 pair_we;
  logic [PAIR_AW-1:0]   pair_waddr;
  count_t               pair_wdata;

  // last write of each memory, for back-to-back hits on one counter
  logic                 letter_fwd_valid;
  logic [LETTER_AW-1:0] letter_fwd_addr;
  count_t               letter_fwd_data;
  logic                 pair_fwd_valid;
  logic [PAIR_AW-1:0]   pair_fwd_addr;
  count_t               pair_fwd_data;

  count_t letter_cur;
  count_t pair_cur;
  count_t letter_new;
  count_t pair_new;

  // clearing sweep after reset
  logic               clr_busy;
  logic [PAIR_AW-1:0] clr_addr;

  // result queue
  push_t              out_push;
  logic               pending;
  logic [FIFO_CW-1:0] fifo_level;

  assign in_char   = s_tdata[CHAR_W-1:0];
  assign in_first  = s_tdata[CHAR_W+IDX_W-1:CHAR_W];
  assign in_second = s_tdata[CHAR_W+2*IDX_W-1:CHAR_W+IDX_W];

  // setting the case bit maps upper-case letters onto lower case
  assign folded       = in_char | CASE_BIT;
  assign in_is_letter = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
  assign in_num       = IDX_W'(folded - CHAR_LOWER_A);

  assign pending   = s1_valid && s1.is_read;
  assign s_tready  = !clr_busy &&
                     ((FIFO_CW+1)'(fifo_level) + (FIFO_CW+1)'(pending) <
                      (FIFO_CW+1)'(FIFO_DEPTH));
  assign in_accept = s_tvalid && s_tready;

  // request decode and pair chain update
  always_comb begin
    s1_next             = '0;
    prev_letter_next    = prev_letter;
    prev_is_letter_next = prev_is_letter;
    unique case (req_t'(s_tuser))
      REQ_FEED: begin
        if (in_is_letter) begin
          s1_next.do_letter   = 1'b1;
          s1_next.letter_addr = LETTER_AW'(in_num);
          s1_next.do_pair     = prev_is_letter;
          s1_next.pair_addr   = pair_index(prev_letter, in_num);
          prev_letter_next    = in_num;
          prev_is_letter_next = 1'b1;
        end else begin
          prev_is_letter_next = 1'b0;
        end
      end
      REQ_READ_LETTER: begin
        s1_next.is_read = 1'b1;
        if (in_first < IDX_W'(ALPHABET_SIZE)) begin
          s1_next.letter_addr = LETTER_AW'(in_first);
        end else begin
          s1_next.zero = 1'b1;
        end
      end
      REQ_READ_PAIR: begin
        s1_next.is_read  = 1'b1;
        s1_next.sel_pair = 1'b1;
        if ((in_first < IDX_W'(ALPHABET_SIZE)) && (in_second < IDX_W'(ALPHABET_SIZE))) begin
          s1_next.pair_addr = pair_index(in_first, in_second);
        end else begin
          s1_next.zero = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_letter    <= '0;
      prev_is_letter <= 1'b0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= in_accept;
      if (in_accept) begin
        prev_letter    <= prev_letter_next;
        prev_is_letter <= prev_is_letter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

  // memories: read at accept, written back from the update stage
  always_ff @(posedge clk) begin
    if (letter_we) begin
      letter_mem[letter_waddr] <= letter_wdata;
    end
    letter_rd <= letter_mem[s1_next.letter_addr];
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    pair_rd <= pair_mem[s1_next.pair_addr];
  end

  // the read issued in the same cycle as the previous write missed it
  assign letter_cur = (letter_fwd_valid && (letter_fwd_addr == s1.letter_addr)) ?
                      letter_fwd_data : letter_rd;
  assign pair_cur   = (pair_fwd_valid && (pair_fwd_addr == s1.pair_addr)) ?
                      pair_fwd_data : pair_rd;
  assign letter_new = bump(letter_cur);
  assign pair_new   = bump(pair_cur);

  // write port: clearing sweep or counter update
  always_comb begin
    if (clr_busy) begin
      letter_we    = (clr_addr < PAIR_AW'(ALPHABET_SIZE));
      letter_waddr = LETTER_AW'(clr_addr);
      letter_wdata = '0;
      pair_we      = 1'b1;
      pair_waddr   = clr_addr;
      pair_wdata   = '0;
    end else begin
      letter_we    = s1_valid && s1.do_letter;
      letter_waddr = s1.letter_addr;
      letter_wdata = letter_new;
      pair_we      = s1_valid && s1.do_pair;
      pair_waddr   = s1.pair_addr;
      pair_wdata   = pair_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_fwd_valid <= 1'b0;
      pair_fwd_valid   <= 1'b0;
    end else begin
      letter_fwd_valid <= s1_valid && s1.do_letter;
      pair_fwd_valid   <= s1_valid && s1.do_pair;
    end
  end

  always_ff @(posedge clk) begin
    letter_fwd_addr <= s1.letter_addr;
    letter_fwd_data <= letter_new;
    pair_fwd_addr   <= s1.pair_addr;
    pair_fwd_data   <= pair_new;
  end

  // one entry per cycle from the bottom of the pair table
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == PAIR_AW'(PAIR_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= PAIR_AW'(clr_addr + PAIR_AW'(1));
    end
  end

  // read results into the queue
  always_comb begin
    out_push.valid = pending;
    if (s1.zero) begin
      out_push.data = '0;
    end else if (s1.sel_pair) begin
      out_push.data = clip_out(pair_cur);
    end else begin
      out_push.data = clip_out(letter_cur);
    end
  end

  lbh_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .level    (fifo_level),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // a push into a full queue would lose a result
  `LBH_ASSERT_NEVER(a_queue_overflow, out_push.valid && (fifo_level == FIFO_CW'(FIFO_DEPTH)) && !(m_tvalid && m_tready), "result queue overflow")
  // the sweep must never race a counter update
  `LBH_ASSERT_IMP(a_clear_idle, clr_busy, !s1_valid, "transaction in flight during clearing sweep")
  // pair updates only come with a letter update and stay inside the table
  `LBH_ASSERT_IMP(a_pair_addr, s1_valid && s1.do_pair, s1.do_letter && (s1.pair_addr < PAIR_AW'(PAIR_DEPTH)), "bad pair update")

endmodule
